// ===== hw/rtl/hp_pkg.sv =====
package hp_pkg;

	localparam logic [1:0] SUITE_AES128 = 2'd0;
	localparam logic [1:0] SUITE_AES256 = 2'd1;
	localparam logic [1:0] SUITE_CHACHA = 2'd2;

	localparam logic [2:0] REG_SUITE = 3'd0;
	localparam logic [2:0] REG_KEY0  = 3'd1;
	localparam logic [2:0] REG_KEY1  = 3'd2;
	localparam logic [2:0] REG_KEY2  = 3'd3;
	localparam logic [2:0] REG_KEY3  = 3'd4;

	localparam int NumRounds = 20;
	localparam int Aes128Rounds = 10;
	localparam int Aes256Rounds = 14;

	localparam logic [31:0] CC_CONST0 = 32'h61707865;
	localparam logic [31:0] CC_CONST1 = 32'h3320646e;
	localparam logic [31:0] CC_CONST2 = 32'h79622d32;
	localparam logic [31:0] CC_CONST3 = 32'h6b206574;

	// sideband fields travelling with each word
	typedef struct packed {
		logic        cmd;
		logic [7:0]  first_byte;
		logic        long_header;
		logic [31:0] pn_field;
		logic [15:0] avail;
	} side_t;

	// AES: [127:0] state, [255:128] newest key chunk, [383:256] previous chunk
	// ChaCha: sixteen 32-bit words, word i at [32*i +: 32]
	typedef logic [511:0] state_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input int j);
		logic [7:0] r;
		case (j)
			1:       r = 8'h01;
			2:       r = 8'h02;
			3:       r = 8'h04;
			4:       r = 8'h08;
			5:       r = 8'h10;
			6:       r = 8'h20;
			7:       r = 8'h40;
			8:       r = 8'h80;
			9:       r = 8'h1b;
			10:      r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// byte i of a chunk at [8*i +: 8]
	function automatic logic [127:0] next_chunk(input logic [127:0] older,
			input logic [127:0] newer, input logic rot, input logic [7:0] rc);
		logic [31:0]  tmp;
		logic [127:0] res;
		if (rot) begin
			tmp = {SBOX[newer[103:96]], SBOX[newer[127:120]],
				SBOX[newer[119:112]], SBOX[newer[111:104]] ^ rc};
		end else begin
			tmp = {SBOX[newer[127:120]], SBOX[newer[119:112]],
				SBOX[newer[111:104]], SBOX[newer[103:96]]};
		end
		res[31:0] = older[31:0] ^ tmp;
		for (int c = 1; c < 4; c++) begin
			res[32*c +: 32] = older[32*c +: 32] ^ res[32*(c-1) +: 32];
		end
		return res;
	endfunction

	function automatic logic [127:0] aes_round(input logic [127:0] s,
			input logic [127:0] rk, input logic last);
		logic [127:0] t;
		logic [7:0]   a0, a1, a2, a3, all;
		for (int c = 0; c < 4; c++) begin
			for (int q = 0; q < 4; q++) begin
				t[8*(q+4*c) +: 8] = SBOX[s[8*(q + 4*((c+q) & 3)) +: 8]];
			end
		end
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[8*(4*c) +: 8];
				a1 = t[8*(4*c+1) +: 8];
				a2 = t[8*(4*c+2) +: 8];
				a3 = t[8*(4*c+3) +: 8];
				all = a0 ^ a1 ^ a2 ^ a3;
				t[8*(4*c) +: 8]   = a0 ^ all ^ xtime(a0 ^ a1);
				t[8*(4*c+1) +: 8] = a1 ^ all ^ xtime(a1 ^ a2);
				t[8*(4*c+2) +: 8] = a2 ^ all ^ xtime(a2 ^ a3);
				t[8*(4*c+3) +: 8] = a3 ^ all ^ xtime(a3 ^ a0);
			end
		end
		return t ^ rk;
	endfunction

	function automatic state_t cc_round(input state_t x, input logic diag);
		state_t      y;
		logic [31:0] a, b, c, d;
		int          ib, ic, id;
		y = x;
		for (int i = 0; i < 4; i++) begin
			ib = 4 + ((i + (diag ? 1 : 0)) & 3);
			ic = 8 + ((i + (diag ? 2 : 0)) & 3);
			id = 12 + ((i + (diag ? 3 : 0)) & 3);
			a = x[32*i +: 32];
			b = x[32*ib +: 32];
			c = x[32*ic +: 32];
			d = x[32*id +: 32];
			a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
			c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
			a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
			c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
			y[32*i +: 32]  = a;
			y[32*ib +: 32] = b;
			y[32*ic +: 32] = c;
			y[32*id +: 32] = d;
		end
		return y;
	endfunction

endpackage

// ===== hw/rtl/hp_round.sv =====
module hp_round #(
	parameter int RND = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     suite,
	input  logic           valid_in,
	input  hp_pkg::state_t st_in,
	input  hp_pkg::side_t  side_in,
	output logic           ready_up,
	output logic           valid_s1,
	output hp_pkg::state_t st_s1,
	output hp_pkg::side_t  side_s1,
	input  logic           ready_dn
);
	import hp_pkg::*;

	localparam bit RndEven = (RND % 2) == 0;

	logic         a256;
	logic [127:0] s, p1, p2, rk, np1, np2;
	int           nr;
	state_t       st_nx;

	assign a256 = (suite == SUITE_AES256);
	assign s    = st_in[127:0];
	assign p1   = st_in[255:128];
	assign p2   = st_in[383:256];

	always_comb begin
		nr    = a256 ? Aes256Rounds : Aes128Rounds;
		rk    = p1;
		np1   = p1;
		np2   = p2;
		st_nx = st_in;
		if (suite == SUITE_CHACHA) begin
			st_nx = cc_round(st_in, RndEven);
		end else if (RND <= nr) begin
			if (!a256) begin
				rk  = next_chunk(p1, p1, 1'b1, rcon(RND));
				np1 = rk;
			end else if (RND != 1) begin
				rk  = next_chunk(p2, p1, RndEven, rcon(RND / 2));
				np1 = rk;
				np2 = p1;
			end
			st_nx = {st_in[511:384], np2, np1, aes_round(s, rk, RND == nr)};
		end
	end

	assign ready_up = ~valid_s1 | ready_dn;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_up) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			st_s1   <= st_nx;
			side_s1 <= side_in;
		end
	end

endmodule

// ===== hw/rtl/hp_final.sv =====
module hp_final (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [1:0]     suite,
	input  logic           valid_in,
	input  hp_pkg::state_t st_in,
	input  hp_pkg::side_t  side_in,
	output logic           ready_up,
	output logic           out_valid,
	input  logic           out_ready,
	output logic           status,
	output logic [7:0]     first_byte_out,
	output logic [31:0]    pn_field_out,
	output logic [2:0]     pn_length
);
	import hp_pkg::*;

	logic [31:0] v0;
	logic [7:0]  v1, m0, m1, m2, m3, m4, hmask, fb_x, plain;
	logic [2:0]  n;
	logic        trunc;
	logic [31:0] pmask;

	always_comb begin
		v0 = st_in[31:0] + CC_CONST0;
		v1 = st_in[39:32] + CC_CONST1[7:0];
		if (suite == SUITE_CHACHA) begin
			{m3, m2, m1, m0} = v0;
			m4 = v1;
		end else begin
			{m4, m3, m2, m1, m0} = st_in[39:0];
		end
		hmask = side_in.long_header ? 8'h0f : 8'h1f;
		fb_x  = side_in.first_byte ^ (m0 & hmask);
		plain = side_in.cmd ? side_in.first_byte : fb_x;
		n     = {1'b0, plain[1:0]} + 3'd1;
		trunc = side_in.avail < {13'd0, n};
		pmask = {m1, (n >= 3'd2) ? m2 : 8'h00, (n >= 3'd3) ? m3 : 8'h00,
			(n == 3'd4) ? m4 : 8'h00};
	end

	assign ready_up = ~out_valid | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ready_up) begin
			out_valid <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_up && valid_in) begin
			status         <= trunc;
			first_byte_out <= trunc ? side_in.first_byte : fb_x;
			pn_field_out   <= trunc ? side_in.pn_field : side_in.pn_field ^ pmask;
			pn_length      <= n;
		end
	end

endmodule

// ===== hw/rtl/packet_header_protection.sv =====
// channel | signals                                   | dir
// input   | in_valid/in_ready, cmd .. bytes_after_pn  | in
// output  | out_valid/out_ready, status .. pn_length  | out
// config  | cfg_we, cfg_index, cfg_data               | in
//
// One word per cycle while the output is not stalled, through 22 register stages:
// one load stage, 20 round stages (one ChaCha round or one AES round with its round
// key each; stages past the last AES round pass the word on), one output stage.
// Reset clears the valid bits and the configuration registers.
// A stage holds only while full and its successor cannot take a word, so bubbles
// close up under an output stall.
module packet_header_protection (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [63:0] sample_high,
	input  logic [63:0] sample_low,
	input  logic [7:0]  first_byte_in,
	input  logic        long_header,
	input  logic [31:0] pn_field_in,
	input  logic [15:0] bytes_after_pn_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [7:0]  first_byte_out,
	output logic [31:0] pn_field_out,
	output logic [2:0]  pn_length
);
	import hp_pkg::*;

	logic [1:0]   cipher_suite_q;
	logic [63:0]  key_q [4];
	logic [255:0] kb;
	logic [127:0] sb;
	state_t       st_init;
	side_t        side_init;

	logic   vld_s0;
	state_t st_s0;
	side_t  sd_s0;

	logic   vld [NumRounds+1];
	state_t st  [NumRounds+1];
	side_t  sd  [NumRounds+1];
	logic   rdy [NumRounds+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cipher_suite_q <= SUITE_AES128;
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= 64'd0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUITE: cipher_suite_q <= cfg_data[1:0];
				REG_KEY0:  key_q[0] <= cfg_data;
				REG_KEY1:  key_q[1] <= cfg_data;
				REG_KEY2:  key_q[2] <= cfg_data;
				REG_KEY3:  key_q[3] <= cfg_data;
				default:   ;
			endcase
		end
	end

	// byte-little views: byte i at [8*i +: 8]
	always_comb begin
		for (int i = 0; i < 32; i++) begin
			kb[8*i +: 8] = key_q[i/8][63 - 8*(i%8) -: 8];
		end
		for (int i = 0; i < 8; i++) begin
			sb[8*i +: 8]     = sample_high[63 - 8*i -: 8];
			sb[8*(i+8) +: 8] = sample_low[63 - 8*i -: 8];
		end
		if (cipher_suite_q == SUITE_CHACHA) begin
			st_init = {sb, kb, CC_CONST3, CC_CONST2, CC_CONST1, CC_CONST0};
		end else begin
			st_init = {128'd0, kb[127:0],
				(cipher_suite_q == SUITE_AES256) ? kb[255:128] : kb[127:0],
				sb ^ kb[127:0]};
		end
		side_init = '{cmd: cmd, first_byte: first_byte_in, long_header: long_header,
			pn_field: pn_field_in, avail: bytes_after_pn_offset};
	end

	assign rdy[0]   = ~vld_s0 | rdy[1];
	assign in_ready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (rdy[0]) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			st_s0 <= st_init;
			sd_s0 <= side_init;
		end
	end

	assign vld[0] = vld_s0;
	assign st[0]  = st_s0;
	assign sd[0]  = sd_s0;

	for (genvar g = 1; g <= NumRounds; g++) begin : g_rnd
		hp_round #(.RND(g)) u_round (
			.clk      (clk),
			.arst_n   (arst_n),
			.suite    (cipher_suite_q),
			.valid_in (vld[g-1]),
			.st_in    (st[g-1]),
			.side_in  (sd[g-1]),
			.ready_up (rdy[g]),
			.valid_s1 (vld[g]),
			.st_s1    (st[g]),
			.side_s1  (sd[g]),
			.ready_dn (rdy[g+1])
		);
	end

	hp_final u_final (
		.clk            (clk),
		.arst_n         (arst_n),
		.suite          (cipher_suite_q),
		.valid_in       (vld[NumRounds]),
		.st_in          (st[NumRounds]),
		.side_in        (sd[NumRounds]),
		.ready_up       (rdy[NumRounds+1]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.first_byte_out (first_byte_out),
		.pn_field_out   (pn_field_out),
		.pn_length      (pn_length)
	);

	// input can only block when the output end is full and stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input blocked without output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pn_length != 3'd0 && pn_length <= 3'd4))
		else $error("pn_length out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped");

endmodule

// ===== tb/tb_packet_header_protection.sv =====
module tb_packet_header_protection;
	import hp_pkg::*;

	localparam logic [1:0] SUITE_SPARE = 2'd3;

	typedef struct packed {
		logic        status;
		logic [7:0]  first_byte;
		logic [31:0] pn_field;
		logic [2:0]  pn_length;
	} hp_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [63:0] sample_high;
	logic [63:0] sample_low;
	logic [7:0]  first_byte_in;
	logic        long_header;
	logic [31:0] pn_field_in;
	logic [15:0] bytes_after_pn_offset;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [7:0]  first_byte_out;
	logic [31:0] pn_field_out;
	logic [2:0]  pn_length;

	logic [1:0]  suite_q;
	logic [63:0] key_q [4];
	hp_result_t  expected_q [$];
	int          errors;
	int          idle_pct;
	int          stall_hold;
	bit          no_idle;
	int          quiet_cycles;

	packet_header_protection dut (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [127:0] aes_mask(input logic [255:0] key, input int nk,
			input logic [127:0] blk);
		logic [7:0] rk [240];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] w [4];
		logic [7:0] tmp, rc, a0, a1, a2, a3, all;
		logic [127:0] res;
		int nr, total;
		nr = nk + 6;
		total = 4 * (nr + 1);
		rc = 8'h01;
		for (int i = 0; i < 4 * nk; i++) rk[i] = key[255 - 8*i -: 8];
		for (int i = nk; i < total; i++) begin
			for (int c = 0; c < 4; c++) w[c] = rk[4*(i-1) + c];
			if (i % nk == 0) begin
				tmp = w[0];
				w[0] = SBOX[w[1]] ^ rc;
				w[1] = SBOX[w[2]];
				w[2] = SBOX[w[3]];
				w[3] = SBOX[tmp];
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end else if (nk > 6 && i % nk == 4) begin
				for (int c = 0; c < 4; c++) w[c] = SBOX[w[c]];
			end
			for (int c = 0; c < 4; c++) rk[4*i + c] = rk[4*(i-nk) + c] ^ w[c];
		end
		for (int i = 0; i < 16; i++) s[i] = blk[127 - 8*i -: 8] ^ rk[i];
		for (int r = 1; r <= nr; r++) begin
			for (int c = 0; c < 4; c++)
				for (int q = 0; q < 4; q++) t[q + 4*c] = SBOX[s[q + 4*((c+q) & 3)]];
			if (r != nr) begin
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					all = a0 ^ a1 ^ a2 ^ a3;
					t[4*c]   = a0 ^ all ^ ({a0[6:0] ^ a1[6:0], 1'b0} ^ ((a0[7]^a1[7]) ? 8'h1b : 8'h00));
					t[4*c+1] = a1 ^ all ^ ({a1[6:0] ^ a2[6:0], 1'b0} ^ ((a1[7]^a2[7]) ? 8'h1b : 8'h00));
					t[4*c+2] = a2 ^ all ^ ({a2[6:0] ^ a3[6:0], 1'b0} ^ ((a2[7]^a3[7]) ? 8'h1b : 8'h00));
					t[4*c+3] = a3 ^ all ^ ({a3[6:0] ^ a0[6:0], 1'b0} ^ ((a3[7]^a0[7]) ? 8'h1b : 8'h00));
				end
			end
			for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*r + i];
		end
		for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
		return res;
	endfunction

	function automatic logic [31:0] le32(input logic [31:0] be);
		return {be[7:0], be[15:8], be[23:16], be[31:24]};
	endfunction

	function automatic logic [39:0] chacha_mask(input logic [255:0] key,
			input logic [127:0] blk);
		logic [31:0] init [16];
		logic [31:0] x [16];
		logic [31:0] v;
		logic [39:0] res;
		int a, b, c, d;
		init[0] = CC_CONST0; init[1] = CC_CONST1; init[2] = CC_CONST2; init[3] = CC_CONST3;
		for (int i = 0; i < 8; i++) init[4+i] = le32(key[255 - 32*i -: 32]);
		for (int i = 0; i < 4; i++) init[12+i] = le32(blk[127 - 32*i -: 32]);
		x = init;
		for (int r = 0; r < 20; r++) begin
			for (int i = 0; i < 4; i++) begin
				a = i;
				b = 4 + ((i + r % 2) & 3);
				c = 8 + ((i + 2 * (r % 2)) & 3);
				d = 12 + ((i + 3 * (r % 2)) & 3);
				x[a] += x[b]; x[d] ^= x[a]; x[d] = {x[d][15:0], x[d][31:16]};
				x[c] += x[d]; x[b] ^= x[c]; x[b] = {x[b][19:0], x[b][31:20]};
				x[a] += x[b]; x[d] ^= x[a]; x[d] = {x[d][23:0], x[d][31:24]};
				x[c] += x[d]; x[b] ^= x[c]; x[b] = {x[b][24:0], x[b][31:25]};
			end
		end
		v = x[0] + init[0];
		res[39:8] = {v[7:0], v[15:8], v[23:16], v[31:24]};
		v = x[1] + init[1];
		res[7:0] = v[7:0];
		return res;
	endfunction

	function automatic hp_result_t predict_header(input logic c, input logic [127:0] smp,
			input logic [7:0] fb, input logic lh, input logic [31:0] pn, input logic [15:0] avail);
		logic [255:0] key;
		logic [39:0]  mask;
		logic [127:0] blk;
		logic [7:0]   fb_out, plain;
		logic [2:0]   n;
		hp_result_t   r;
		key = {key_q[0], key_q[1], key_q[2], key_q[3]};
		if (suite_q == SUITE_CHACHA) begin
			mask = chacha_mask(key, smp);
		end else begin
			blk = aes_mask(key, suite_q == SUITE_AES256 ? 8 : 4, smp);
			mask = blk[127:88];
		end
		fb_out = fb ^ (mask[39:32] & (lh ? 8'h0f : 8'h1f));
		plain = c ? fb : fb_out;
		n = 3'd1 + plain[1:0];
		r.pn_length = n;
		if (avail < n) begin
			r.status = 1'b1;
			r.first_byte = fb;
			r.pn_field = pn;
		end else begin
			r.status = 1'b0;
			r.first_byte = fb_out;
			r.pn_field = pn;
			for (int i = 0; i < n; i++) r.pn_field[31 - 8*i -: 8] ^= mask[31 - 8*i -: 8];
		end
		return r;
	endfunction

	function automatic bit go_now();
		return no_idle || ($urandom_range(99) >= idle_pct);
	endfunction

	task automatic send_word(input logic c, input logic [127:0] smp, input logic [7:0] fb,
			input logic lh, input logic [31:0] pn, input logic [15:0] avail);
		while (!go_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		sample_high <= smp[127:64];
		sample_low <= smp[63:0];
		first_byte_in <= fb;
		long_header <= lh;
		pn_field_in <= pn;
		bytes_after_pn_offset <= avail;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		expected_q.push_back(predict_header(c, smp, fb, lh, pn, avail));
	endtask

	task automatic send_random(input int count);
		logic [15:0] avail;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: avail = 16'($urandom_range(4));
				1: avail = 16'($urandom);
				default: avail = 16'($urandom_range(5, 1500));
			endcase
			send_word(1'($urandom), {$urandom, $urandom, $urandom, $urandom}, 8'($urandom),
				1'($urandom), $urandom, avail);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_SUITE: suite_q = val[1:0];
			REG_KEY0:  key_q[0] = val;
			REG_KEY1:  key_q[1] = val;
			REG_KEY2:  key_q[2] = val;
			REG_KEY3:  key_q[3] = val;
			default: ;
		endcase
	endtask

	task automatic load_keys(input logic [1:0] suite, input logic [255:0] key);
		wait_drained();
		write_reg(REG_SUITE, {62'd0, suite});
		write_reg(REG_KEY0, key[255:192]);
		write_reg(REG_KEY1, key[191:128]);
		write_reg(REG_KEY2, key[127:64]);
		write_reg(REG_KEY3, key[63:0]);
		cfg_we <= 1'b0;
	endtask

	task automatic test_directed();
		send_word(1'b0, '0, 8'h00, 1'b0, 32'h0, 16'h0);
		send_word(1'b1, '1, 8'hff, 1'b1, 32'hffffffff, 16'hffff);
		for (int i = 0; i < 4; i++) begin
			send_word(1'b1, {4{$urandom}}, 8'hc0 | i[7:0], 1'b1, $urandom, 16'(i));
			send_word(1'b1, {4{$urandom}}, 8'h40 | i[7:0], 1'b0, $urandom, 16'(i + 1));
		end
		for (int i = 0; i < 6; i++)
			send_word(1'b0, {$urandom, $urandom, $urandom, $urandom}, 8'($urandom), i[0],
				$urandom, 16'($urandom_range(4)));
	endtask

	task automatic test_suites();
		load_keys(SUITE_AES128, {$urandom, $urandom, $urandom, $urandom, 128'd0});
		test_directed();
		send_random(150);
		load_keys(SUITE_AES256, {8{$urandom}});
		send_random(150);
		load_keys(SUITE_CHACHA, '1);
		test_directed();
		send_random(150);
		load_keys(SUITE_CHACHA, {8{$urandom}});
		send_random(150);
		load_keys(SUITE_SPARE, {8{$urandom}});
		send_random(100);
		load_keys(SUITE_AES256, '0);
		send_random(50);
	endtask

	task automatic test_no_idle();
		load_keys(SUITE_AES128, {8{$urandom}});
		no_idle = 1'b1;
		send_random(200);
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		load_keys(SUITE_CHACHA, {8{$urandom}});
		stall_hold = 150;
		send_random(150);
		wait_drained();
		send_random(60);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= go_now();
		end
	end

	always @(posedge clk) begin
		hp_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: result word with nothing expected: %h %h %h %h", $time,
					status, first_byte_out, pn_field_out, pn_length);
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (status !== exp_r.status) begin
					$display("%0t: status exp %h got %h", $time, exp_r.status, status);
					errors++;
				end
				if (first_byte_out !== exp_r.first_byte) begin
					$display("%0t: first_byte exp %h got %h", $time, exp_r.first_byte,
						first_byte_out);
					errors++;
				end
				if (pn_field_out !== exp_r.pn_field) begin
					$display("%0t: pn_field exp %h got %h", $time, exp_r.pn_field,
						pn_field_out);
					errors++;
				end
				if (pn_length !== exp_r.pn_length) begin
					$display("%0t: pn_length exp %h got %h", $time, exp_r.pn_length,
						pn_length);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > 5000) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		idle_pct = 26;
		stall_hold = 0;
		no_idle = 1'b0;
		quiet_cycles = 0;
		suite_q = '0;
		for (int i = 0; i < 4; i++) key_q[i] = '0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = 1'b0;
		sample_high = '0;
		sample_low = '0;
		first_byte_in = '0;
		long_header = 1'b0;
		pn_field_in = '0;
		bytes_after_pn_offset = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_random(10);
		test_suites();
		test_no_idle();
		test_backpressure();
		wait_drained();
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
